// File: sv/sbh_pkg.sv
package sbh_pkg;

  localparam int unsigned MAX_WIDTH_DEF   = 4096;
  localparam int unsigned FRAME_WIDTH_RST  = 640;
  localparam int unsigned FRAME_HEIGHT_RST = 480;

  localparam int unsigned PIX_W     = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 16;
  localparam int unsigned WIDTH_W   = 13;
  localparam int unsigned HEIGHT_W  = 16;

  typedef logic [PIX_W-1:0] pixel_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1
  } cfg_idx_e;

  // one column of the two previous rows
  typedef struct packed {
    pixel_t above2;
    pixel_t above;
  } line_word_t;

endpackage

// File: sv/sobel_horizontal_3x3.sv
// Horizontal 3x3 Sobel gradient over a raster-order stream of 8-bit pixels. One pixel is
// taken per clock unless an output stall holds stage 1. A pixel is registered in stage 1
// with its line store read, and its result in the output register. A result is given only
// when the 3x3 window is complete (row >= 2 and column >= 2 of the frame), as the low 8
// bits of (left column - right column) with weight 2 on the middle row; frame_last_o marks
// the result of the final pixel of the frame. Both line stores share one memory, read and
// written once per pixel. frame_width (clamped to 3..MAX_WIDTH) and frame_height (at least
// 3) are written through the config port; the user must write them only while the block is
// idle, which the block does not enforce. A write to either restarts the frame but keeps
// the line store contents. The block needs no clearing pass after reset.
module sobel_horizontal_3x3 #(
  parameter int unsigned MAX_WIDTH = sbh_pkg::MAX_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  sbh_pkg::pixel_t                pixel_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output sbh_pkg::pixel_t                gradient_o,
  output logic                           frame_last_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [sbh_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [sbh_pkg::CFG_DAT_W-1:0]  cfg_data_i
);
  import sbh_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned EW = WIDTH_W + 1;
  localparam logic [EW-1:0] MAX_W_E = EW'(MAX_WIDTH);
  localparam int unsigned W_RST = (FRAME_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : FRAME_WIDTH_RST;
  localparam logic [CW-1:0] W_LAST_RST = CW'(W_RST - 1);
  localparam logic [HEIGHT_W-1:0] H_LAST_RST = HEIGHT_W'(FRAME_HEIGHT_RST - 1);

  typedef struct packed {
    logic            emit;
    logic            last;
    logic [CW-1:0]   col;
    pixel_t          px;
  } s1_t;

  logic                cfg_we;
  logic [CW-1:0]       w_last_q, w_last_d;
  logic [HEIGHT_W-1:0] h_last_q, h_last_d;
  logic [EW-1:0]       w_in, w_eff;
  logic [HEIGHT_W-1:0] h_in;

  logic                acc;
  logic [CW-1:0]       col_q;
  logic [HEIGHT_W-1:0] row_q;
  logic                col_end, row_end;

  logic                s1_v_q;
  s1_t                 s1_q;
  logic                s1_adv;
  line_word_t          rd_word;

  pixel_t              wt1_q, wt2_q, wm1_q, wm2_q, wb1_q, wb2_q;
  logic [9:0]          left_sum, right_sum, diff;

  logic                out_valid_q;
  pixel_t              gradient_q;
  logic                frame_last_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_comb begin
    w_in = {1'b0, cfg_data_i[WIDTH_W-1:0]};
    if (w_in < EW'(3)) begin
      w_eff = EW'(3);
    end else if (w_in > MAX_W_E) begin
      w_eff = MAX_W_E;
    end else begin
      w_eff = w_in;
    end
    w_last_d = CW'(w_eff - EW'(1));
    h_in = cfg_data_i[HEIGHT_W-1:0];
    if (h_in < HEIGHT_W'(3)) begin
      h_last_d = HEIGHT_W'(2);
    end else begin
      h_last_d = h_in - HEIGHT_W'(1);
    end
  end

  // pipeline control
  assign s1_adv     = s1_v_q && (!s1_q.emit || !out_valid_q || !out_stall_i);
  assign in_stall_o = s1_v_q && !s1_adv;
  assign acc        = in_valid_i && !in_stall_o;
  assign col_end    = (col_q == w_last_q);
  assign row_end    = (row_q == h_last_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_last_q <= W_LAST_RST;
      h_last_q <= H_LAST_RST;
      col_q    <= '0;
      row_q    <= '0;
    end else if (cfg_we && (cfg_index_i == CFG_FRAME_WIDTH
                            || cfg_index_i == CFG_FRAME_HEIGHT)) begin
      if (cfg_index_i == CFG_FRAME_WIDTH) begin
        w_last_q <= w_last_d;
      end else begin
        h_last_q <= h_last_d;
      end
      col_q <= '0;
      row_q <= '0;
    end else if (acc) begin
      if (col_end) begin
        col_q <= '0;
        row_q <= row_end ? '0 : row_q + HEIGHT_W'(1);
      end else begin
        col_q <= col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (acc) begin
      s1_v_q <= 1'b1;
    end else if (s1_adv) begin
      s1_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_q.emit <= (row_q >= HEIGHT_W'(2)) && (col_q >= CW'(2));
      s1_q.last <= row_end && col_end;
      s1_q.col  <= col_q;
      s1_q.px   <= pixel_i;
    end
  end

  // older row moves down a slot, new pixel becomes the previous row
  sbh_line_store #(
    .Depth(MAX_WIDTH)
  ) u_line_store (
    .clk_i     (clk_i),
    .rd_en_i   (acc),
    .rd_addr_i (col_q),
    .rd_data_o (rd_word),
    .wr_en_i   (s1_adv),
    .wr_addr_i (s1_q.col),
    .wr_data_i (line_word_t'{above2: rd_word.above, above: s1_q.px})
  );

  // window left column minus new right column
  always_comb begin
    left_sum  = {2'b00, wt1_q} + {1'b0, wm1_q, 1'b0} + {2'b00, wb1_q};
    right_sum = {2'b00, rd_word.above2} + {1'b0, rd_word.above, 1'b0} + {2'b00, s1_q.px};
    diff      = left_sum - right_sum;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wt1_q <= '0;
      wt2_q <= '0;
      wm1_q <= '0;
      wm2_q <= '0;
      wb1_q <= '0;
      wb2_q <= '0;
    end else if (cfg_we && (cfg_index_i == CFG_FRAME_WIDTH
                            || cfg_index_i == CFG_FRAME_HEIGHT)) begin
      wt1_q <= '0;
      wt2_q <= '0;
      wm1_q <= '0;
      wm2_q <= '0;
      wb1_q <= '0;
      wb2_q <= '0;
    end else if (s1_adv) begin
      wt1_q <= wt2_q;
      wm1_q <= wm2_q;
      wb1_q <= wb2_q;
      wt2_q <= rd_word.above2;
      wm2_q <= rd_word.above;
      wb2_q <= s1_q.px;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_q.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_q.emit) begin
      gradient_q   <= diff[PIX_W-1:0];
      frame_last_q <= s1_q.last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign gradient_o   = gradient_q;
  assign frame_last_o = frame_last_q;

  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= w_last_q)
    else $error("column counter beyond row end");

  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && col_end && row_end && !cfg_we |=> col_q == '0 && row_q == '0)
    else $error("counters did not wrap at frame end");

  a_empty_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_v_q |-> !in_stall_o)
    else $error("input stalled with empty stage");

  a_emit_only_late: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && (row_q < HEIGHT_W'(2) || col_q < CW'(2)) |=> !s1_q.emit)
    else $error("result flagged for border pixel");

endmodule

// File: sv/sbh_line_store.sv
module sbh_line_store #(
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output sbh_pkg::line_word_t      rd_data_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  sbh_pkg::line_word_t      wr_data_i
);
  import sbh_pkg::*;

  line_word_t mem [Depth];
  line_word_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
